// ----- hdl/lbp_pkg.sv -----
// Package for the light bar pair target selector.
// Holds the store geometry, the rectangle record, register indexes and the sequencer states.
// Used by the top level, the checker and the testbench; depends on nothing.
package lbp_pkg;

	localparam int MAX_RECTS = 64;
	localparam int ADDR_W = $clog2(MAX_RECTS);
	localparam int CNT_W = $clog2(MAX_RECTS + 1);

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
		logic signed [11:0] a;
		logic [15:0] h;
		logic [15:0] w;
	} rect_t;

	localparam int RECT_W = $bits(rect_t);

	typedef enum logic [2:0] {
		REG_AREA_MIN = 3'd0,
		REG_AREA_MAX = 3'd1,
		REG_GROUP_DX = 3'd2,
		REG_GROUP_DY = 3'd3,
		REG_MAX_ANGLE = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AREA,
		ST_FILT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_FRAME,
		ST_B0_RD,
		ST_B0_MUL,
		ST_B0_AR,
		ST_B_RD,
		ST_B_MUL,
		ST_B_DEC,
		ST_B_LAST,
		ST_P_CHK,
		ST_PI_RD,
		ST_PI_MUL,
		ST_PI_AR,
		ST_PJ_RD,
		ST_PJ_LD,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_CMP,
		ST_UPD,
		ST_OUT
	} state_t;

	// A light bar stands upright: height is the long side; angles at or below -45 degrees gain 90.
	function automatic rect_t to_bar(input rect_t r);
		rect_t b;
		b = r;
		if (r.h < r.w) begin
			b.h = r.w;
			b.w = r.h;
		end
		if (r.a <= -12'sd720) begin
			b.a = r.a + 12'sd1440;
		end
		return b;
	endfunction

endpackage

// ----- hdl/lbp_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Depends on nothing; instantiated for the rectangle store and the light bar store.
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/lbp_mul.sv -----
// Shared 16 by 16 bit unsigned multiplier with a registered product.
// Depends on nothing; every area, square and height product goes through it.
module lbp_mul (
	input  logic        clk,
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [31:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ----- hdl/light_bar_pair_target_selector.sv -----
// Light bar pair target selector, top level.
// Depends on lbp_pkg, lbp_ram and lbp_mul.
//
// Usage: one frame of rotated rectangles enters on the input channel
// (in_valid / in_stall), one request per rectangle, the final one marked by
// last. Rectangles that pass the area and orientation limits are kept, while
// the store has room, in a store sorted by center x. The request with last
// set makes one result on the output channel (out_valid / out_stall): found,
// is_big and the midpoint of the chosen pair; other requests make none.
// After a request is taken in_stall stays high while the rectangle is tested
// against the limits and, when it is kept, while insertion moves each stored
// entry with larger x up by one place (insertion walks the store through its
// single read port). A request is taken in a cycle in which in_stall is low.
// The end of a frame groups the stored rectangles into bars, then tests every
// bar pair, all on the one shared multiplier, and then loads the output register.
// in_stall is high in every state but idle, so also while a frame end runs or
// waits for the output register to empty. The result sits in an output
// register; a held out_stall keeps it there, and the next frame end waits
// only if that register is still full.
// Reset clears the counts, the sequencer and the output valid, and loads the
// default limits; the store contents need no clearing. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and belong in idle time.
module light_bar_pair_target_selector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        center_x,
	input  logic [15:0]        center_y,
	input  logic [15:0]        rect_width,
	input  logic [15:0]        rect_height,
	input  logic signed [11:0] rect_angle,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic               is_big,
	output logic [15:0]        target_x,
	output logic [15:0]        target_y
);

	lbp_pkg::state_t state_q, state_d;

	logic [15:0] area_min_q, area_max_q;
	logic [11:0] group_dx_q, group_dy_q;
	logic [10:0] max_angle_q;

	logic [lbp_pkg::CNT_W-1:0] rcnt_q, bcnt_q, pos_q, idx_q, pi_q, pj_q;
	logic best_have_q, out_valid_q;

	lbp_pkg::rect_t in_q, prev_q, cur_q, rep_q, bi_q, bj_q;
	logic last_q;
	logic [31:0] rep_area_q, area_i_q, h2_q;
	logic [32:0] d2_q;
	logic [15:0] dx_q, dy_q, hh_q, ss_q;
	logic [12:0] da_q;
	logic pass_q, isbig_q;
	logic signed [35:0] score_q, best_score_q;
	logic best_big_q;
	logic [15:0] best_x_q, best_y_q;
	logic found_q, is_big_q;
	logic [15:0] tx_q, ty_q;

	logic rect_we, bar_we;
	logic [lbp_pkg::ADDR_W-1:0] rect_waddr, rect_raddr, bar_waddr, bar_raddr;
	lbp_pkg::rect_t rect_wdata, rect_rd, bar_wdata, bar_rd;
	logic [15:0] mul_a, mul_b;
	logic [31:0] prod;

	lbp_ram #(.WIDTH(lbp_pkg::RECT_W), .DEPTH(lbp_pkg::MAX_RECTS)) u_rect_ram (
		.clk(clk), .we(rect_we), .waddr(rect_waddr), .wdata(rect_wdata),
		.raddr(rect_raddr), .rdata(rect_rd)
	);

	lbp_ram #(.WIDTH(lbp_pkg::RECT_W), .DEPTH(lbp_pkg::MAX_RECTS)) u_bar_ram (
		.clk(clk), .we(bar_we), .waddr(bar_waddr), .wdata(bar_wdata),
		.raddr(bar_raddr), .rdata(bar_rd)
	);

	lbp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	// Filter terms for the incoming rectangle.
	logic signed [12:0] ang_ext;
	logic [12:0] ang_abs;
	logic keep;
	assign ang_ext = {in_q.a[11], in_q.a};
	assign ang_abs = ang_ext < 0 ? 13'(-ang_ext) : 13'(ang_ext);
	assign keep = ((ang_abs < 13'd720 && in_q.h > in_q.w)
		|| (ang_abs > 13'd720 && in_q.w > in_q.h))
		&& prod > {8'd0, area_min_q, 8'd0} && prod < {8'd0, area_max_q, 8'd0}
		&& rcnt_q < lbp_pkg::CNT_W'(lbp_pkg::MAX_RECTS);

	logic shift_up;
	assign shift_up = rect_rd.x > in_q.x;

	// Grouping test between neighbors in x order.
	logic [15:0] gdx, gdy;
	logic grouped;
	assign gdx = cur_q.x - prev_q.x;
	assign gdy = cur_q.y > prev_q.y ? cur_q.y - prev_q.y : prev_q.y - cur_q.y;
	assign grouped = gdx < {4'd0, group_dx_q} && gdy < {4'd0, group_dy_q};

	// Plate tests for the current pair.
	logic [47:0] d2w, h2w;
	logic [21:0] hh20, ss27, dy10, ss17;
	logic common, small_ok, big_ok;
	logic signed [35:0] score;
	assign d2w = 48'(d2_q);
	assign h2w = 48'(h2_q);
	assign hh20 = 22'(hh_q) * 22'd20;
	assign ss27 = 22'(ss_q) * 22'd27;
	assign dy10 = 22'(dy_q) * 22'd10;
	assign ss17 = 22'(ss_q) * 22'd17;
	assign common = hh20 < ss27 && da_q < {2'd0, max_angle_q};
	assign small_ok = common && d2w * 48'd4 >= h2w * 48'd9
		&& d2w * 48'd400 <= h2w * 48'd3481 && dy_q < ss_q;
	assign big_ok = common && d2w * 48'd25 >= h2w * 48'd256
		&& d2w * 48'd4 <= h2w * 48'd121 && dy10 < ss17;
	assign score = 36'(area_i_q) + 36'(prod) - 36'(da_q) * 36'sd80
		+ (big_ok ? 36'sd1280 : 36'sd0);

	logic signed [12:0] ai_ext, aj_ext;
	assign ai_ext = {bi_q.a[11], bi_q.a};
	assign aj_ext = {bar_rd.a[11], bar_rd.a};

	logic [16:0] sum_x, sum_y;
	assign sum_x = {1'b0, bi_q.x} + {1'b0, bj_q.x};
	assign sum_y = {1'b0, bi_q.y} + {1'b0, bj_q.y};

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbp_pkg::ST_IDLE:     if (in_valid) state_d = lbp_pkg::ST_AREA;
			lbp_pkg::ST_AREA:     state_d = lbp_pkg::ST_FILT;
			lbp_pkg::ST_FILT: begin
				if (keep) state_d = lbp_pkg::ST_SCAN_RD;
				else if (last_q) state_d = lbp_pkg::ST_FRAME;
				else state_d = lbp_pkg::ST_IDLE;
			end
			lbp_pkg::ST_SCAN_RD: begin
				if (pos_q != '0) state_d = lbp_pkg::ST_SCAN_CMP;
				else if (last_q) state_d = lbp_pkg::ST_FRAME;
				else state_d = lbp_pkg::ST_IDLE;
			end
			lbp_pkg::ST_SCAN_CMP: begin
				if (shift_up) state_d = lbp_pkg::ST_SCAN_RD;
				else if (last_q) state_d = lbp_pkg::ST_FRAME;
				else state_d = lbp_pkg::ST_IDLE;
			end
			lbp_pkg::ST_FRAME: begin
				if (rcnt_q < lbp_pkg::CNT_W'(2)) state_d = lbp_pkg::ST_OUT;
				else state_d = lbp_pkg::ST_B0_RD;
			end
			lbp_pkg::ST_B0_RD:    state_d = lbp_pkg::ST_B0_MUL;
			lbp_pkg::ST_B0_MUL:   state_d = lbp_pkg::ST_B0_AR;
			lbp_pkg::ST_B0_AR:    state_d = lbp_pkg::ST_B_RD;
			lbp_pkg::ST_B_RD:     state_d = lbp_pkg::ST_B_MUL;
			lbp_pkg::ST_B_MUL:    state_d = lbp_pkg::ST_B_DEC;
			lbp_pkg::ST_B_DEC: begin
				if (idx_q + 1'b1 == rcnt_q) state_d = lbp_pkg::ST_B_LAST;
				else state_d = lbp_pkg::ST_B_RD;
			end
			lbp_pkg::ST_B_LAST:   state_d = lbp_pkg::ST_P_CHK;
			lbp_pkg::ST_P_CHK: begin
				if (bcnt_q < lbp_pkg::CNT_W'(2)) state_d = lbp_pkg::ST_OUT;
				else state_d = lbp_pkg::ST_PI_RD;
			end
			lbp_pkg::ST_PI_RD:    state_d = lbp_pkg::ST_PI_MUL;
			lbp_pkg::ST_PI_MUL:   state_d = lbp_pkg::ST_PI_AR;
			lbp_pkg::ST_PI_AR:    state_d = lbp_pkg::ST_PJ_RD;
			lbp_pkg::ST_PJ_RD:    state_d = lbp_pkg::ST_PJ_LD;
			lbp_pkg::ST_PJ_LD:    state_d = lbp_pkg::ST_M1;
			lbp_pkg::ST_M1:       state_d = lbp_pkg::ST_M2;
			lbp_pkg::ST_M2:       state_d = lbp_pkg::ST_M3;
			lbp_pkg::ST_M3:       state_d = lbp_pkg::ST_M4;
			lbp_pkg::ST_M4:       state_d = lbp_pkg::ST_CMP;
			lbp_pkg::ST_CMP:      state_d = lbp_pkg::ST_UPD;
			lbp_pkg::ST_UPD: begin
				if (pj_q + 1'b1 != bcnt_q) state_d = lbp_pkg::ST_PJ_RD;
				else if (pi_q + 2'd2 == bcnt_q) state_d = lbp_pkg::ST_OUT;
				else state_d = lbp_pkg::ST_PI_RD;
			end
			lbp_pkg::ST_OUT:      if (!out_valid_q) state_d = lbp_pkg::ST_IDLE;
			default:              state_d = lbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rect_we = 1'b0;
		rect_waddr = pos_q[lbp_pkg::ADDR_W-1:0];
		rect_wdata = in_q;
		rect_raddr = '0;
		bar_we = 1'b0;
		bar_waddr = bcnt_q[lbp_pkg::ADDR_W-1:0];
		bar_wdata = lbp_pkg::to_bar(rep_q);
		bar_raddr = pi_q[lbp_pkg::ADDR_W-1:0];
		mul_a = in_q.w;
		mul_b = in_q.h;
		case (state_q)
			lbp_pkg::ST_SCAN_RD: begin
				rect_raddr = lbp_pkg::ADDR_W'(pos_q - 1'b1);
				rect_we = pos_q == '0;
			end
			lbp_pkg::ST_SCAN_CMP: begin
				rect_we = 1'b1;
				rect_wdata = shift_up ? rect_rd : in_q;
			end
			lbp_pkg::ST_B_RD:     rect_raddr = idx_q[lbp_pkg::ADDR_W-1:0];
			lbp_pkg::ST_B0_MUL, lbp_pkg::ST_B_MUL: begin
				mul_a = rect_rd.w;
				mul_b = rect_rd.h;
			end
			lbp_pkg::ST_B_DEC:    bar_we = !grouped;
			lbp_pkg::ST_B_LAST:   bar_we = 1'b1;
			lbp_pkg::ST_PI_MUL: begin
				mul_a = bar_rd.w;
				mul_b = bar_rd.h;
			end
			lbp_pkg::ST_PJ_RD:    bar_raddr = pj_q[lbp_pkg::ADDR_W-1:0];
			lbp_pkg::ST_M1: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			lbp_pkg::ST_M2: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			lbp_pkg::ST_M3: begin
				mul_a = hh_q;
				mul_b = hh_q;
			end
			lbp_pkg::ST_M4: begin
				mul_a = bj_q.w;
				mul_b = bj_q.h;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbp_pkg::ST_IDLE;
			area_min_q <= 16'd12;
			area_max_q <= 16'd10000;
			group_dx_q <= 12'd160;
			group_dy_q <= 12'd480;
			max_angle_q <= 11'd160;
			rcnt_q <= '0;
			bcnt_q <= '0;
			pos_q <= '0;
			idx_q <= '0;
			pi_q <= '0;
			pj_q <= '0;
			best_have_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					lbp_pkg::REG_AREA_MIN:  area_min_q <= cfg_data;
					lbp_pkg::REG_AREA_MAX:  area_max_q <= cfg_data;
					lbp_pkg::REG_GROUP_DX:  group_dx_q <= cfg_data[11:0];
					lbp_pkg::REG_GROUP_DY:  group_dy_q <= cfg_data[11:0];
					lbp_pkg::REG_MAX_ANGLE: max_angle_q <= cfg_data[10:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lbp_pkg::ST_FILT:     pos_q <= rcnt_q;
				lbp_pkg::ST_SCAN_RD:  if (pos_q == '0) rcnt_q <= rcnt_q + 1'b1;
				lbp_pkg::ST_SCAN_CMP: begin
					if (shift_up) pos_q <= pos_q - 1'b1;
					else rcnt_q <= rcnt_q + 1'b1;
				end
				lbp_pkg::ST_FRAME: begin
					best_have_q <= 1'b0;
					bcnt_q <= '0;
				end
				lbp_pkg::ST_B0_AR:    idx_q <= lbp_pkg::CNT_W'(1);
				lbp_pkg::ST_B_DEC: begin
					idx_q <= idx_q + 1'b1;
					if (!grouped) bcnt_q <= bcnt_q + 1'b1;
				end
				lbp_pkg::ST_B_LAST:   bcnt_q <= bcnt_q + 1'b1;
				lbp_pkg::ST_P_CHK:    pi_q <= '0;
				lbp_pkg::ST_PI_AR:    pj_q <= pi_q + 1'b1;
				lbp_pkg::ST_UPD: begin
					if (pass_q && (!best_have_q || score_q > best_score_q)) begin
						best_have_q <= 1'b1;
					end
					pj_q <= pj_q + 1'b1;
					if (pj_q + 1'b1 == bcnt_q) pi_q <= pi_q + 1'b1;
				end
				lbp_pkg::ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						rcnt_q <= '0;
						bcnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		case (state_q)
			lbp_pkg::ST_IDLE: begin
				in_q <= '{y: center_y, x: center_x, a: rect_angle, h: rect_height, w: rect_width};
				last_q <= last;
			end
			lbp_pkg::ST_B0_MUL: begin
				rep_q <= rect_rd;
				prev_q <= rect_rd;
			end
			lbp_pkg::ST_B0_AR:    rep_area_q <= prod;
			lbp_pkg::ST_B_MUL:    cur_q <= rect_rd;
			lbp_pkg::ST_B_DEC: begin
				if (!grouped || prod > rep_area_q) begin
					rep_q <= cur_q;
					rep_area_q <= prod;
				end
				prev_q <= cur_q;
			end
			lbp_pkg::ST_PI_MUL:   bi_q <= bar_rd;
			lbp_pkg::ST_PI_AR:    area_i_q <= prod;
			lbp_pkg::ST_PJ_LD: begin
				bj_q <= bar_rd;
				dx_q <= bi_q.x > bar_rd.x ? bi_q.x - bar_rd.x : bar_rd.x - bi_q.x;
				dy_q <= bi_q.y > bar_rd.y ? bi_q.y - bar_rd.y : bar_rd.y - bi_q.y;
				hh_q <= bi_q.h > bar_rd.h ? bi_q.h : bar_rd.h;
				ss_q <= bi_q.h < bar_rd.h ? bi_q.h : bar_rd.h;
				da_q <= ai_ext > aj_ext ? 13'(ai_ext - aj_ext) : 13'(aj_ext - ai_ext);
			end
			lbp_pkg::ST_M2:       d2_q <= {1'b0, prod};
			lbp_pkg::ST_M3:       d2_q <= d2_q + {1'b0, prod};
			lbp_pkg::ST_M4:       h2_q <= prod;
			lbp_pkg::ST_CMP: begin
				pass_q <= small_ok || big_ok;
				isbig_q <= big_ok;
				score_q <= score;
			end
			lbp_pkg::ST_UPD: begin
				if (pass_q && (!best_have_q || score_q > best_score_q)) begin
					best_score_q <= score_q;
					best_big_q <= isbig_q;
					best_x_q <= sum_x[16:1];
					best_y_q <= sum_y[16:1];
				end
			end
			lbp_pkg::ST_OUT: begin
				if (!out_valid_q) begin
					found_q <= best_have_q;
					is_big_q <= best_have_q & best_big_q;
					tx_q <= best_have_q ? best_x_q : 16'd0;
					ty_q <= best_have_q ? best_y_q : 16'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = state_q != lbp_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign found = found_q;
	assign is_big = is_big_q;
	assign target_x = tx_q;
	assign target_y = ty_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= lbp_pkg::CNT_W'(lbp_pkg::MAX_RECTS))
		else $error("rectangle count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= rcnt_q)
		else $error("more light bars than rectangles");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lbp_pkg::ST_OUT))
		else $error("result raised outside the output step");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbp_pkg::ST_PJ_RD |-> pj_q > pi_q && pj_q < bcnt_q)
		else $error("pair index out of order");

endmodule

// ----- dv/lbp_checker.sv -----
// Checker for the light bar pair target selector: watches the register port and both channels.
// Predicts the frame result for every request with last set and compares it field by field.
// Depends on lbp_pkg for the rectangle record, the store size and the register indexes.
module lbp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        center_x,
	input  logic [15:0]        center_y,
	input  logic [15:0]        rect_width,
	input  logic [15:0]        rect_height,
	input  logic signed [11:0] rect_angle,
	input  logic               last,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               found,
	input  logic               is_big,
	input  logic [15:0]        target_x,
	input  logic [15:0]        target_y,
	output int                 fail_count,
	output int                 pending,
	output int                 hits_seen
);

	typedef struct {
		logic        found;
		logic        is_big;
		logic [15:0] tx;
		logic [15:0] ty;
	} verdict_t;

	verdict_t frame_results[$];

	longint lim_area_min, lim_area_max, lim_dx, lim_dy, lim_angle;

	lbp_pkg::rect_t sorted_rects[lbp_pkg::MAX_RECTS];
	int     n_rects;
	longint bx[lbp_pkg::MAX_RECTS], by[lbp_pkg::MAX_RECTS], bw[lbp_pkg::MAX_RECTS];
	longint bh[lbp_pkg::MAX_RECTS], ba[lbp_pkg::MAX_RECTS];
	int     n_bars;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void add_bar(input lbp_pkg::rect_t r);
		longint w, h, a;
		w = r.w;
		h = r.h;
		a = r.a;
		if (h < w) begin
			w = r.h;
			h = r.w;
		end
		if (a <= -720) begin
			a = a + 1440;
		end
		bx[n_bars] = r.x;
		by[n_bars] = r.y;
		bw[n_bars] = w;
		bh[n_bars] = h;
		ba[n_bars] = a;
		n_bars++;
	endfunction

	// Neighbors in x order form a group; the largest area in a group becomes the bar.
	function automatic void group_bars();
		int     rep;
		longint rep_area, dx, dy, ar;
		rep = 0;
		rep_area = longint'(sorted_rects[0].w) * sorted_rects[0].h;
		n_bars = 0;
		for (int i = 1; i < n_rects; i++) begin
			dx = longint'(sorted_rects[i].x) - sorted_rects[i-1].x;
			dy = longint'(sorted_rects[i].y) - sorted_rects[i-1].y;
			if (dy < 0) dy = -dy;
			ar = longint'(sorted_rects[i].w) * sorted_rects[i].h;
			if (dx < lim_dx && dy < lim_dy) begin
				if (ar > rep_area) begin
					rep = i;
					rep_area = ar;
				end
			end else begin
				add_bar(sorted_rects[rep]);
				rep = i;
				rep_area = ar;
			end
		end
		add_bar(sorted_rects[rep]);
	endfunction

	function automatic verdict_t pick_pair();
		verdict_t v;
		bit       have, sm, bg, common;
		longint   dx, dy, d2, hh, ss, h2, da, sc, best;
		v = '{1'b0, 1'b0, 16'd0, 16'd0};
		have = 0;
		best = 0;
		for (int i = 0; i + 1 < n_bars; i++) begin
			for (int j = i + 1; j < n_bars; j++) begin
				dx = bx[i] - bx[j];
				if (dx < 0) dx = -dx;
				dy = by[i] - by[j];
				if (dy < 0) dy = -dy;
				d2 = dx * dx + dy * dy;
				hh = bh[i] > bh[j] ? bh[i] : bh[j];
				ss = bh[i] < bh[j] ? bh[i] : bh[j];
				h2 = hh * hh;
				da = ba[i] - ba[j];
				if (da < 0) da = -da;
				common = (20 * hh < 27 * ss) && (da < lim_angle);
				sm = common && 4 * d2 >= 9 * h2 && 400 * d2 <= 3481 * h2 && dy < ss;
				bg = common && 25 * d2 >= 256 * h2 && 4 * d2 <= 121 * h2 && 10 * dy < 17 * ss;
				if (sm || bg) begin
					sc = bw[i] * bh[i] + bw[j] * bh[j] - 80 * da + (bg ? 1280 : 0);
					if (!have || sc > best) begin
						have = 1;
						best = sc;
						v.found = 1'b1;
						v.is_big = bg;
						v.tx = 16'((bx[i] + bx[j]) >> 1);
						v.ty = 16'((by[i] + by[j]) >> 1);
					end
				end
			end
		end
		return v;
	endfunction

	function automatic void take_rect(input lbp_pkg::rect_t r, input logic lst);
		longint   ar, aa;
		bit       upright;
		int       pos;
		verdict_t v;
		ar = longint'(r.w) * r.h;
		aa = r.a;
		if (aa < 0) aa = -aa;
		upright = (aa < 720 && r.h > r.w) || (aa > 720 && r.w > r.h);
		if (upright && ar > lim_area_min * 256 && ar < lim_area_max * 256
				&& n_rects < lbp_pkg::MAX_RECTS) begin
			pos = n_rects;
			while (pos > 0 && sorted_rects[pos-1].x > r.x) begin
				sorted_rects[pos] = sorted_rects[pos-1];
				pos--;
			end
			sorted_rects[pos] = r;
			n_rects++;
		end
		if (lst) begin
			v = '{1'b0, 1'b0, 16'd0, 16'd0};
			if (n_rects >= 2) begin
				group_bars();
				if (n_bars >= 2) v = pick_pair();
			end
			frame_results.insert(frame_results.size(), v);
			n_rects = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		lbp_pkg::rect_t r;
		if (!arst_n) begin
			lim_area_min = 12;
			lim_area_max = 10000;
			lim_dx = 160;
			lim_dy = 480;
			lim_angle = 160;
			n_rects = 0;
			frame_results.delete();
			fail_count = 0;
			hits_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lbp_pkg::REG_AREA_MIN: lim_area_min = cfg_data;
					lbp_pkg::REG_AREA_MAX: lim_area_max = cfg_data;
					lbp_pkg::REG_GROUP_DX: lim_dx = cfg_data[11:0];
					lbp_pkg::REG_GROUP_DY: lim_dy = cfg_data[11:0];
					lbp_pkg::REG_MAX_ANGLE: lim_angle = cfg_data[10:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					report("result with no frame waiting, found", found, 0);
				end else begin
					v = frame_results.pop_front();
					if (found !== v.found) report("found", found, v.found);
					if (is_big !== v.is_big) report("is_big", is_big, v.is_big);
					if (target_x !== v.tx) report("target_x", target_x, v.tx);
					if (target_y !== v.ty) report("target_y", target_y, v.ty);
					if (v.found) hits_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				r.x = center_x;
				r.y = center_y;
				r.w = rect_width;
				r.h = rect_height;
				r.a = rect_angle;
				take_rect(r, last);
			end
			pending = frame_results.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the light bar pair target selector: clock, reset, stimulus and verdict.
// Sends directed and random frames of rectangles under several limit settings and idle patterns.
// Depends on lbp_pkg, the block itself and lbp_checker.
module tb;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        center_x, center_y, rect_width, rect_height;
	logic signed [11:0] rect_angle;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic               found, is_big;
	logic [15:0]        target_x, target_y;
	logic               hold_on;

	int fail_count, pending, hits_seen;
	int idle_pct, stall_pct;
	int items_sent, frames_sent;

	always #5 clk = ~clk;

	light_bar_pair_target_selector u_dut (.*);

	lbp_checker u_chk (.*);

	always @(posedge clk) begin
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	task automatic send_rect(input int x, input int y, input int w, input int h,
			input int a, input bit lst);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= 16'(x);
		center_y <= 16'(y);
		rect_width <= 16'(w);
		rect_height <= 16'(h);
		rect_angle <= 12'(a);
		last <= lst;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (lst) frames_sent++;
	endtask

	task automatic write_limit(input lbp_pkg::reg_idx_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		@(posedge clk);
	endtask

	// Limits change only once the last frame's result is out and the block has settled.
	task automatic set_limits(input int amin, input int amax, input int gdx, input int gdy,
			input int mad);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		write_limit(lbp_pkg::REG_AREA_MIN, amin);
		write_limit(lbp_pkg::REG_AREA_MAX, amax);
		write_limit(lbp_pkg::REG_GROUP_DX, gdx);
		write_limit(lbp_pkg::REG_GROUP_DY, gdy);
		write_limit(lbp_pkg::REG_MAX_ANGLE, mad);
		cfg_we <= 1'b0;
	endtask

	// Most bars sit in slots (one of six, or one per bar in long frames) spaced by 1.2 to
	// 6 times their height, so that both plate sizes, grouping and arrival out of x order come up.
	task automatic send_frame();
		int n, h0, x0, y0, sp, slot, x, y, w, h, a, t;
		n = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
		h0 = $urandom_range(160, 1600);
		x0 = $urandom_range(0, 20000);
		y0 = $urandom_range(500, 60000);
		sp = h0 * $urandom_range(12, 60) / 10;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) < 2) begin
				x = $urandom_range(65535);
				y = $urandom_range(65535);
				w = $urandom_range(65535) >> $urandom_range(15);
				h = $urandom_range(65535) >> $urandom_range(15);
				a = $urandom_range(4095);
			end else begin
				slot = (n > 20) ? k : $urandom_range(0, 5);
				x = x0 + slot * sp + $urandom_range(0, 40);
				y = y0 + $urandom_range(0, 120) - 60;
				h = h0 + $urandom_range(0, 80) - 40;
				w = h / $urandom_range(2, 5);
				a = -$urandom_range(0, 150);
				if ($urandom_range(3) == 0) begin
					t = w;
					w = h;
					h = t;
					a = -1440 + $urandom_range(0, 150);
				end
			end
			send_rect(x, y, w, h, a, k == n - 1);
		end
	endtask

	task automatic random_frames(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) send_frame();
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 76; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 76; end
			default: begin idle_pct = 30; stall_pct = 30; end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lbp_pkg::REG_AREA_MIN;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		center_x = 16'd0;
		center_y = 16'd0;
		rect_width = 16'd0;
		rect_height = 16'd0;
		rect_angle = 12'sd0;
		last = 1'b0;
		hold_on = 1'b0;
		items_sent = 0;
		frames_sent = 0;
		set_idling(0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_limits(12, 10000, 160, 480, 160);
		// Small plate, then big plate with one bar lying on its side.
		send_rect(1000, 2000, 128, 480, 0, 0);
		send_rect(1960, 2010, 128, 470, -16, 1);
		send_rect(3000, 3000, 130, 480, -10, 0);
		send_rect(4920, 3000, 480, 130, -1430, 1);
		// A lone rectangle, then a frame whose only rectangle sits exactly at 45 degrees.
		send_rect(500, 500, 100, 400, 0, 1);
		send_rect(0, 0, 128, 480, -720, 1);
		// Field extremes and angles outside the nominal range.
		send_rect(65535, 65535, 65535, 65535, -1440, 0);
		send_rect(0, 0, 0, 0, 0, 0);
		send_rect(65535, 0, 100, 65535, 2047, 0);
		send_rect(0, 65535, 300, 200, -2048, 1);
		// Neighbors that group, one tying in x with another, and a partner bar.
		send_rect(1000, 1000, 100, 400, 0, 0);
		send_rect(1050, 1100, 120, 420, 0, 0);
		send_rect(1050, 1000, 120, 420, -5, 0);
		send_rect(2900, 1000, 120, 420, -5, 1);
		random_frames(240);

		set_limits(0, 65535, 4095, 4095, 1440);
		set_idling(1);
		random_frames(240);

		set_limits(65535, 0, 0, 0, 0);
		set_idling(2);
		random_frames(160);

		set_limits(0, 65535, 0, 4095, 0);
		set_idling(3);
		random_frames(240);

		set_limits(12, 10000, 160, 480, 160);
		set_idling(0);
		// The receiver holds off while frames keep coming, so the block backs up.
		fork
			begin
				hold_on <= 1'b1;
				repeat (1500) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		random_frames(240);

		set_limits($urandom_range(0, 40), $urandom_range(2000, 65535), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 1440));
		set_idling(3);
		random_frames(240);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d rectangles in %0d frames over six limit settings and four idle mixes.",
				items_sent, frames_sent);
		$display("%0d frames reported a plate pair; receiver backpressure was held once.",
				hits_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#80000000;
		$display("Timed out with %0d frame results still outstanding.", pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/lbp_pkg.sv
hdl/lbp_ram.sv
hdl/lbp_mul.sv
hdl/light_bar_pair_target_selector.sv
dv/lbp_checker.sv
dv/tb.sv
